// ----- hdl/ocv_pkg.sv -----
// Shared constants for the OCV state-of-charge interpolator.
// Command codes, register indexes and fixed field widths; no dependencies.
package ocv_pkg;

   // Widths of the fixed fields of the request, result and register port
   localparam int ENTRY_INDEX_BITS = 7;
   localparam int SOC_BITS         = 10;
   localparam int CSR_DATA_BITS    = 16;
   localparam int CSR_INDEX_BITS   = 1;

   // Command field codes
   localparam logic CMD_WRITE    = 1'b0;
   localparam logic CMD_ESTIMATE = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVALID_LOW  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVALID_HIGH = 1'b1;

   // Result scaling
   localparam int TENTHS_PER_PERCENT = 10;
   localparam int SOC_MAX            = 1000;

endpackage

// ----- hdl/ocv_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module ocv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 101
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ocv_soc_interpolator.sv -----
// Top level of the OCV state-of-charge interpolator.
// Depends on ocv_pkg (constants) and ocv_ram (curve storage).

// The block keeps an open-circuit-voltage curve, one voltage per percent point, in a
// RAM of CURVE_POINTS entries; a stored zero means no data. A write beat (command 0)
// stores one entry and gives no result; an index beyond the curve is dropped. An
// estimate beat (command 1) reads the whole curve from the top entry down, one RAM
// read per cycle, then decides the ends, the invalid window, an exact match or a flat
// area; only a true interpolation goes on to one multiply and a restoring divider
// that retires one quotient bit a cycle. The next request beat can be taken at the
// earliest in the same cycle as the result is raised. The curve scan through the
// single RAM read port and the bit-serial divider set how long an estimate takes.
// One estimate is in work at a time; the next beat is taken while a finished result
// still waits in the output register. After reset a clearing pass writes zero to
// every entry, one per cycle, and no request beat is taken meanwhile; register
// writes are taken at any time but belong to idle periods.
module ocv_soc_interpolator #(
   parameter int CURVE_POINTS = 101,
   parameter int VOLTAGE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_command,
   input  logic [ocv_pkg::ENTRY_INDEX_BITS-1:0]  req_entry_index,
   input  logic [VOLTAGE_BITS-1:0]               req_entry_voltage,
   input  logic [VOLTAGE_BITS-1:0]               req_cell_voltage,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ocv_pkg::SOC_BITS-1:0]          rsp_soc_tenths,
   output logic                                  rsp_soc_valid,
   // register write port
   input  logic                                  csr_wr_en,
   input  logic [ocv_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ocv_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int VB   = VOLTAGE_BITS;
   localparam int AW   = $clog2(CURVE_POINTS);
   localparam int TOP  = CURVE_POINTS - 1;
   localparam int IW   = (AW > ocv_pkg::ENTRY_INDEX_BITS) ? AW : ocv_pkg::ENTRY_INDEX_BITS;
   localparam int XW   = (VB > ocv_pkg::CSR_DATA_BITS) ? VB : ocv_pkg::CSR_DATA_BITS;
   localparam int PW   = AW + VB;      // |hi-lo| * (v-Vlo)
   localparam int NW   = PW + 5;       // dividend: 20 * product +- span
   localparam int DW   = VB + 1;       // divisor: twice the span
   localparam int CNTW = $clog2(NW + 1);
   localparam int RW   = NW + 2;       // signed result before saturation
   localparam int SW   = ocv_pkg::SOC_BITS;
   localparam int TOP_X10 = TOP * ocv_pkg::TENTHS_PER_PERCENT;
   localparam logic [SW-1:0] TOP_TENTHS =
      SW'((TOP_X10 > ocv_pkg::SOC_MAX) ? ocv_pkg::SOC_MAX : TOP_X10);
   localparam logic [AW-1:0] TOP_ADDR = AW'(TOP);

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_SCAN   = 9'b000000100,
      ST_DECIDE = 9'b000001000,
      ST_MULT   = 9'b000010000,
      ST_PREP   = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_CALC   = 9'b010000000,
      ST_FIN    = 9'b100000000
   } state_type;

   // control registers
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [VB-1:0]     inv_low_ff, inv_low_in;
   logic [VB-1:0]     inv_high_ff, inv_high_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              scan_run_ff, scan_run_in;
   logic              rd_vld_ff, rd_vld_in;

   // datapath registers
   logic [AW-1:0]     scan_addr_ff, scan_addr_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [VB-1:0]     v_ff, v_in;
   logic [VB-1:0]     v0_ff, v0_in;
   logic [VB-1:0]     vtop_ff, vtop_in;
   logic              lo_found_ff, lo_found_in;
   logic              hi_found_ff, hi_found_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [VB-1:0]     vlo_ff, vlo_in;
   logic [VB-1:0]     vhi_ff, vhi_in;
   logic              match_ff, match_in;
   logic [AW-1:0]     match_idx_ff, match_idx_in;
   logic              seek_ff, seek_in;
   logic              flat_ff, flat_in;
   logic              s_neg_ff, s_neg_in;
   logic [VB-1:0]     d_ff, d_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic              neg_ff, neg_in;
   logic [NW-1:0]     num_ff, num_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic [SW-1:0]     res_tenths_ff, res_tenths_in;
   logic              res_ok_ff, res_ok_in;
   logic [SW-1:0]     rsp_tenths_ff, rsp_tenths_in;
   logic              rsp_ok_ff, rsp_ok_in;

   // RAM port signals
   logic              ram_we;
   logic [AW-1:0]     ram_wr_addr;
   logic [VB-1:0]     ram_wr_data;
   logic [VB-1:0]     ram_rd_data;

   // helpers
   logic              req_fire;
   logic              idx_in_range;
   logic [IW-1:0]     idx_wide;
   logic [XW-1:0]     csr_wide;
   logic              in_window;
   logic              e_filled;
   logic [AW+3:0]     match_x10;
   logic [AW-1:0]     abs_s;
   logic [VB-1:0]     w_diff;
   logic [NW-1:0]     m20;
   logic [NW-1:0]     d_wide;
   logic [DW:0]       rem_shift;
   logic [DW:0]       div_sub;
   logic signed [RW-1:0] lo10_s;
   logic signed [RW-1:0] t_s;
   logic signed [RW-1:0] r_s;
   logic [RW-1:0]     q_up;

   ocv_ram #(
      .WIDTH (VB),
      .DEPTH (CURVE_POINTS)
   ) u_curve_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (scan_addr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Write index check in 32 bits so that a curve of 2**AW points still compares right
   assign idx_in_range = (32'(req_entry_index) < 32'(CURVE_POINTS));
   assign idx_wide     = IW'(req_entry_index);
   assign csr_wide     = XW'(csr_wdata);

   // RAM write: clearing pass, or a write beat taken from the request channel
   always_comb begin
      ram_we      = 1'b0;
      ram_wr_addr = idx_wide[AW-1:0];
      ram_wr_data = req_entry_voltage;
      if (state_ff == ST_CLEAR) begin
         ram_we      = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else if (req_fire && req_command == ocv_pkg::CMD_WRITE && idx_in_range) begin
         ram_we = 1'b1;
      end
   end

   assign in_window = (inv_low_ff != inv_high_ff) && (v_ff >= inv_low_ff) &&
                      (v_ff <= inv_high_ff);
   assign e_filled  = (ram_rd_data != '0);
   assign match_x10 = (AW+4)'({match_idx_ff, 3'b000}) + (AW+4)'({match_idx_ff, 1'b0});

   // multiply operands: signed index span split into magnitude and sign
   assign abs_s  = s_neg_in ? (lo_ff - hi_ff) : (hi_ff - lo_ff);
   assign w_diff = v_ff - vlo_ff;

   // 20 * product, built from shifts
   assign m20    = NW'({prod_ff, 4'b0000}) + NW'({prod_ff, 2'b00});
   assign d_wide = NW'(d_ff);

   // one restoring divider step against twice the span
   assign rem_shift = {rem_ff, num_ff[NW-1]};
   assign div_sub   = rem_shift - {1'b0, d_ff, 1'b0};

   // floor correction for a negative dividend, then add 10 * lo
   assign q_up   = RW'(num_ff) + RW'(rem_ff != '0);
   assign t_s    = neg_ff ? -$signed(q_up) : $signed(RW'(num_ff));
   assign lo10_s = $signed(RW'({lo_ff, 3'b000})) + $signed(RW'({lo_ff, 1'b0}));
   assign r_s    = lo10_s + t_s;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      inv_low_in    = inv_low_ff;
      inv_high_in   = inv_high_ff;
      rsp_valid_in  = rsp_valid_ff;
      scan_run_in   = scan_run_ff;
      rd_vld_in     = 1'b0;
      scan_addr_in  = scan_addr_ff;
      rd_idx_in     = scan_addr_ff;
      v_in          = v_ff;
      v0_in         = v0_ff;
      vtop_in       = vtop_ff;
      lo_found_in   = lo_found_ff;
      hi_found_in   = hi_found_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      vlo_in        = vlo_ff;
      vhi_in        = vhi_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      seek_in       = seek_ff;
      flat_in       = flat_ff;
      s_neg_in      = s_neg_ff;
      d_in          = d_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      res_tenths_in = res_tenths_ff;
      res_ok_in     = res_ok_ff;
      rsp_tenths_in = rsp_tenths_ff;
      rsp_ok_in     = rsp_ok_ff;

      // register writes are taken in every state
      if (csr_wr_en) begin
         case (csr_index)
            ocv_pkg::CSR_INVALID_LOW:  inv_low_in  = csr_wide[VB-1:0];
            ocv_pkg::CSR_INVALID_HIGH: inv_high_in = csr_wide[VB-1:0];
            default: ;
         endcase
      end

      // drop the result once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == TOP_ADDR) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire && req_command == ocv_pkg::CMD_ESTIMATE) begin
               v_in         = req_cell_voltage;
               scan_addr_in = TOP_ADDR;
               scan_run_in  = 1'b1;
               lo_found_in  = 1'b0;
               hi_found_in  = 1'b0;
               match_in     = 1'b0;
               seek_in      = 1'b0;
               flat_in      = 1'b0;
               state_in     = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read a cycle, top entry first
            if (scan_run_ff) begin
               rd_vld_in = 1'b1;
               if (scan_addr_ff == '0) begin
                  scan_run_in = 1'b0;
               end else begin
                  scan_addr_in = scan_addr_ff - 1'b1;
               end
            end
            // fold the entry that arrives this cycle into the running search
            if (rd_vld_ff) begin
               if (rd_idx_ff == TOP_ADDR) begin
                  vtop_in = ram_rd_data;
               end
               if (rd_idx_ff == '0) begin
                  v0_in    = ram_rd_data;
                  state_in = ST_DECIDE;
               end
               if (e_filled && v_ff < ram_rd_data) begin
                  hi_found_in = 1'b1;
                  hi_in       = rd_idx_ff;
                  vhi_in      = ram_rd_data;
               end
               if (!lo_found_ff && e_filled && ram_rd_data < v_ff) begin
                  lo_found_in = 1'b1;
                  lo_in       = rd_idx_ff;
                  vlo_in      = ram_rd_data;
               end
               if (seek_ff && e_filled) begin
                  // nearest filled entry below the match: same voltage means flat area
                  flat_in = (ram_rd_data == v_ff);
                  seek_in = 1'b0;
               end else if (!match_ff && ram_rd_data == v_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = rd_idx_ff;
                  seek_in      = 1'b1;
               end
            end
         end

         ST_DECIDE: begin
            res_tenths_in = '0;
            res_ok_in     = 1'b1;
            state_in      = ST_FIN;
            if (in_window) begin
               res_ok_in = 1'b0;
            end else if (v_ff <= v0_ff) begin
               res_ok_in = 1'b1;
            end else if (v_ff >= vtop_ff) begin
               res_tenths_in = TOP_TENTHS;
            end else if (match_ff) begin
               if (flat_ff) begin
                  res_ok_in = 1'b0;
               end else if (32'(match_x10) > 32'(ocv_pkg::SOC_MAX)) begin
                  res_tenths_in = SW'(ocv_pkg::SOC_MAX);
               end else begin
                  res_tenths_in = SW'(match_x10);
               end
            end else if (!lo_found_ff || !hi_found_ff) begin
               res_ok_in = 1'b0;
            end else begin
               state_in = ST_MULT;
            end
         end

         ST_MULT: begin
            s_neg_in = (hi_ff < lo_ff);
            d_in     = vhi_ff - vlo_ff;
            prod_in  = PW'(abs_s) * PW'(w_diff);
            state_in = ST_PREP;
         end

         ST_PREP: begin
            // magnitude and sign of 20*(hi-lo)*(v-Vlo) + span
            if (!s_neg_ff) begin
               num_in = m20 + d_wide;
               neg_in = 1'b0;
            end else if (m20 > d_wide) begin
               num_in = m20 - d_wide;
               neg_in = 1'b1;
            end else begin
               num_in = d_wide - m20;
               neg_in = 1'b0;
            end
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            if (!div_sub[DW]) begin
               rem_in = div_sub[DW-1:0];
               num_in = {num_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[DW-1:0];
               num_in = {num_ff[NW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(NW - 1)) begin
               state_in = ST_CALC;
            end
         end

         ST_CALC: begin
            res_ok_in = 1'b1;
            if (r_s < 0) begin
               res_tenths_in = '0;
            end else if (r_s > $signed(RW'(ocv_pkg::SOC_MAX))) begin
               res_tenths_in = SW'(ocv_pkg::SOC_MAX);
            end else begin
               res_tenths_in = SW'(r_s);
            end
            state_in = ST_FIN;
         end

         ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_tenths_in = res_ok_ff ? res_tenths_ff : '0;
               rsp_ok_in     = res_ok_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         inv_low_ff   <= '0;
         inv_high_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         scan_run_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         inv_low_ff   <= inv_low_in;
         inv_high_ff  <= inv_high_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_run_ff  <= scan_run_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff  <= scan_addr_in;
      rd_idx_ff     <= rd_idx_in;
      v_ff          <= v_in;
      v0_ff         <= v0_in;
      vtop_ff       <= vtop_in;
      lo_found_ff   <= lo_found_in;
      hi_found_ff   <= hi_found_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      vlo_ff        <= vlo_in;
      vhi_ff        <= vhi_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      seek_ff       <= seek_in;
      flat_ff       <= flat_in;
      s_neg_ff      <= s_neg_in;
      d_ff          <= d_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      res_tenths_ff <= res_tenths_in;
      res_ok_ff     <= res_ok_in;
      rsp_tenths_ff <= rsp_tenths_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_soc_tenths = rsp_tenths_ff;
   assign rsp_soc_valid  = rsp_ok_ff;

`ifndef ASSERT_OFF
   // a new result appears only out of the finish state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside finish state");

   // an invalid result carries zero tenths
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_tenths_ff == '0)
      else $error("invalid result with nonzero tenths");

   // saturation keeps every result within 0..1000 tenths
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 32'(rsp_tenths_ff) <= 32'(ocv_pkg::SOC_MAX))
      else $error("result beyond full charge");

   // the curve must not change under a running scan
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !ram_we)
      else $error("curve write during scan");
`endif

endmodule
